### hw/rtl/dbls_pkg.sv
// shared types and constants for the dashed line stepper
`timescale 1ns / 1ps
`default_nettype none

package dbls_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DEC_BITS      = COORD_BITS + 3;
  localparam int DASH_CFG_BITS = 9;
  localparam int DASH_CNT_BITS = 8;

  localparam logic [DASH_CFG_BITS-1:0] DASH_PERIOD_RST = 9'd40;
  localparam logic [DASH_CFG_BITS-1:0] DASH_ON_RST     = 9'd20;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } dbls_op_t;

  typedef enum logic {
    CFG_DASH_PERIOD    = 1'b0,
    CFG_DASH_ON_LENGTH = 1'b1
  } dbls_cfg_idx_t;

  typedef struct packed {
    dbls_op_t                      op;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
  } dbls_cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  px;
    logic signed [COORD_BITS-1:0]  py;
    logic                          visible;
    logic                          last_point;
    logic                          point_valid;
  } dbls_point_t;

  // command after the first stage: absolute deltas and step directions
  typedef struct packed {
    dbls_op_t                      op;
    logic signed [COORD_BITS-1:0]  x0;
    logic signed [COORD_BITS-1:0]  y0;
    logic [COORD_BITS-1:0]         adx;
    logic [COORD_BITS-1:0]         ady;
    logic                          xneg;
    logic                          yneg;
  } dbls_prep_t;

endpackage

`default_nettype wire

### hw/rtl/dashed_bresenham_line_stepper.sv
// Dashed line stepper. Commands come in on cmd (valid/ready): a start
// command loads two endpoints and gives the first point, a step command
// gives the next point of the line. Every command gives exactly one
// result on pt (valid/ready); a step with no line in progress gives a
// result with point_valid low and all other fields zero. A start command
// drops any line in progress.
// Two register stages (delta stage, stepping stage) lie between a command
// and its result on pt. Throughput is one command per cycle while
// the receiver takes every result; the line state loops back
// through the stepping stage.
// When the receiver stalls, the result register holds its point and the
// delta stage holds the next command; cmd_ready drops in the same cycle
// once both are full, and an empty delta stage takes one more command.
// The dash counter runs on across lines; its period and on-length are
// written over the cfg port (index 0 period, index 1 on-length), by the
// user only while the block is idle; the block does not enforce it. Reset
// clears the line state and dash counter, sets period 40, on-length 20.
`timescale 1ns / 1ps
`default_nettype none

module dashed_bresenham_line_stepper
  import dbls_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire dbls_cmd_t                cmd,
  output logic                          pt_valid,
  input  wire logic                     pt_ready,
  output dbls_point_t                   pt,
  input  wire logic                     cfg_we,
  input  wire dbls_cfg_idx_t            cfg_index,
  input  wire logic [DASH_CFG_BITS-1:0] cfg_data
);

  logic       prep_valid;
  logic       prep_ready;
  dbls_prep_t prep;
  logic       dash_adv;
  logic       dash_visible;

  dbls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep)
  );

  dbls_dash u_dash (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (dash_adv),
    .visible   (dash_visible)
  );

  dbls_core u_core (
    .clk          (clk),
    .rst          (rst),
    .prep_valid   (prep_valid),
    .prep_ready   (prep_ready),
    .prep         (prep),
    .dash_adv     (dash_adv),
    .dash_visible (dash_visible),
    .pt_valid     (pt_valid),
    .pt_ready     (pt_ready),
    .pt           (pt)
  );

endmodule

`default_nettype wire

### hw/rtl/dbls_front.sv
// input stage: registers the command with absolute deltas and step signs
`timescale 1ns / 1ps
`default_nettype none

module dbls_front
  import dbls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire dbls_cmd_t  cmd,
  output logic            prep_valid,
  input  wire logic       prep_ready,
  output dbls_prep_t      prep
);

  logic signed [COORD_BITS:0] dx_fwd;
  logic signed [COORD_BITS:0] dx_rev;
  logic signed [COORD_BITS:0] dy_fwd;
  logic signed [COORD_BITS:0] dy_rev;
  logic                       xneg;
  logic                       yneg;
  dbls_prep_t                 prep_next;

  // both directions in parallel, pick by sign
  assign dx_fwd = {cmd.x_end[COORD_BITS-1], cmd.x_end} -
                  {cmd.x_start[COORD_BITS-1], cmd.x_start};
  assign dx_rev = {cmd.x_start[COORD_BITS-1], cmd.x_start} -
                  {cmd.x_end[COORD_BITS-1], cmd.x_end};
  assign dy_fwd = {cmd.y_end[COORD_BITS-1], cmd.y_end} -
                  {cmd.y_start[COORD_BITS-1], cmd.y_start};
  assign dy_rev = {cmd.y_start[COORD_BITS-1], cmd.y_start} -
                  {cmd.y_end[COORD_BITS-1], cmd.y_end};

  assign xneg = dx_fwd[COORD_BITS];
  assign yneg = dy_fwd[COORD_BITS];

  always_comb begin
    prep_next.op   = cmd.op;
    prep_next.x0   = cmd.x_start;
    prep_next.y0   = cmd.y_start;
    prep_next.adx  = xneg ? dx_rev[COORD_BITS-1:0] : dx_fwd[COORD_BITS-1:0];
    prep_next.ady  = yneg ? dy_rev[COORD_BITS-1:0] : dy_fwd[COORD_BITS-1:0];
    prep_next.xneg = xneg;
    prep_next.yneg = yneg;
  end

  assign cmd_ready = !prep_valid || prep_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      prep_valid <= 1'b1;
    end else if (prep_ready) begin
      prep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      prep <= prep_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dbls_dash.sv
// dash pattern registers and the running dash counter
`timescale 1ns / 1ps
`default_nettype none

module dbls_dash
  import dbls_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire dbls_cfg_idx_t            cfg_index,
  input  wire logic [DASH_CFG_BITS-1:0] cfg_data,
  input  wire logic                     adv,
  output logic                          visible
);

  logic [DASH_CFG_BITS-1:0] dash_period;
  logic [DASH_CFG_BITS-1:0] dash_on_length;
  logic [DASH_CNT_BITS-1:0] dash_count;
  logic [DASH_CNT_BITS-1:0] dash_count_next;
  logic [DASH_CNT_BITS-1:0] limit;

  // period of zero wraps at zero, anything from 256 up wraps at 255
  always_comb begin
    if (dash_period == '0) begin
      limit = '0;
    end else if (dash_period[DASH_CFG_BITS-1]) begin
      limit = '1;
    end else begin
      limit = dash_period[DASH_CNT_BITS-1:0] - DASH_CNT_BITS'(1);
    end
    dash_count_next = (dash_count == limit) ? '0 : dash_count + DASH_CNT_BITS'(1);
    visible = {1'b0, dash_count_next} < dash_on_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_period    <= DASH_PERIOD_RST;
      dash_on_length <= DASH_ON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DASH_PERIOD:    dash_period    <= cfg_data;
        CFG_DASH_ON_LENGTH: dash_on_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_count <= '0;
    end else if (adv) begin
      dash_count <= dash_count_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dbls_core.sv
// line state, stepping logic and the result register
`timescale 1ns / 1ps
`default_nettype none

module dbls_core
  import dbls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        prep_valid,
  output logic             prep_ready,
  input  wire dbls_prep_t  prep,
  output logic             dash_adv,
  input  wire logic        dash_visible,
  output logic             pt_valid,
  input  wire logic        pt_ready,
  output dbls_point_t      pt
);

  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [DEC_BITS-1:0]   decision;
  logic [COORD_BITS-1:0]        delta_major;
  logic [COORD_BITS-1:0]        delta_minor;
  logic [COORD_BITS-1:0]        steps_left;
  logic                         xneg;
  logic                         yneg;
  logic                         xmaj;
  logic                         line_active;

  logic                         take;
  logic                         is_start;

  // start path
  logic                         s_xmaj;
  logic [COORD_BITS-1:0]        s_dmaj;
  logic [COORD_BITS-1:0]        s_dmin;
  logic signed [DEC_BITS-1:0]   s_dec;

  // step path
  logic                         dec_pos;
  logic [COORD_BITS-1:0]        x_inc;
  logic [COORD_BITS-1:0]        y_inc;
  logic signed [COORD_BITS-1:0] k_x;
  logic signed [COORD_BITS-1:0] k_y;
  logic signed [DEC_BITS-1:0]   k_adj;
  logic signed [DEC_BITS-1:0]   k_dec;
  logic [COORD_BITS-1:0]        k_steps;

  dbls_point_t                  pt_next;

  assign prep_ready = !pt_valid || pt_ready;
  assign take       = prep_valid && prep_ready;
  assign is_start   = (prep.op == OP_START);

  // y is the major axis on a tie
  always_comb begin
    s_xmaj = prep.adx > prep.ady;
    s_dmaj = s_xmaj ? prep.adx : prep.ady;
    s_dmin = s_xmaj ? prep.ady : prep.adx;
    s_dec  = $signed({2'b00, s_dmin, 1'b0}) - $signed({3'b000, s_dmaj});
  end

  always_comb begin
    dec_pos = !decision[DEC_BITS-1] && (decision != '0);
    x_inc   = xneg ? '1 : COORD_BITS'(1);
    y_inc   = yneg ? '1 : COORD_BITS'(1);
    k_x     = (xmaj || dec_pos) ? cur_x + $signed(x_inc) : cur_x;
    k_y     = (!xmaj || dec_pos) ? cur_y + $signed(y_inc) : cur_y;
    k_adj   = dec_pos ? $signed({2'b00, delta_minor, 1'b0}) - $signed({2'b00, delta_major, 1'b0})
                      : $signed({2'b00, delta_minor, 1'b0});
    k_dec   = decision + k_adj;
    k_steps = steps_left - COORD_BITS'(1);
  end

  assign dash_adv = take && (is_start || line_active);

  always_comb begin
    if (is_start) begin
      pt_next.px          = prep.x0;
      pt_next.py          = prep.y0;
      pt_next.visible     = dash_visible;
      pt_next.last_point  = (s_dmaj == '0);
      pt_next.point_valid = 1'b1;
    end else if (line_active) begin
      pt_next.px          = k_x;
      pt_next.py          = k_y;
      pt_next.visible     = dash_visible;
      pt_next.last_point  = (k_steps == '0);
      pt_next.point_valid = 1'b1;
    end else begin
      pt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      decision    <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      steps_left  <= '0;
      xneg        <= 1'b0;
      yneg        <= 1'b0;
      xmaj        <= 1'b0;
      line_active <= 1'b0;
    end else if (take) begin
      if (is_start) begin
        cur_x       <= prep.x0;
        cur_y       <= prep.y0;
        decision    <= s_dec;
        delta_major <= s_dmaj;
        delta_minor <= s_dmin;
        steps_left  <= s_dmaj;
        xneg        <= prep.xneg;
        yneg        <= prep.yneg;
        xmaj        <= s_xmaj;
        line_active <= (s_dmaj != '0);
      end else if (line_active) begin
        cur_x       <= k_x;
        cur_y       <= k_y;
        decision    <= k_dec;
        steps_left  <= k_steps;
        line_active <= (k_steps != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (take) begin
      pt_valid <= 1'b1;
    end else if (pt_ready) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt <= pt_next;
    end
  end

`ifndef SYNTHESIS
  a_active_has_steps: assert property (@(posedge clk) disable iff (rst)
    line_active |-> steps_left != '0)
    else $error("active line with no steps left");

  a_idle_step_invalid: assert property (@(posedge clk) disable iff (rst)
    take && !is_start && !line_active |=> pt_valid && !pt.point_valid)
    else $error("step without a line gave a valid point");

  a_start_first_point: assert property (@(posedge clk) disable iff (rst)
    take && is_start |=> pt_valid && pt.point_valid &&
      pt.px == $past(prep.x0) && pt.py == $past(prep.y0))
    else $error("start did not emit its first endpoint");

  a_invalid_point_clear: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt.point_valid |-> !pt.visible && !pt.last_point)
    else $error("invalid point carries flags");
`endif

endmodule

`default_nettype wire
